>>> design/gsmmn_pkg.sv
// Shared types and constants for the grid store with min-max normalization.
package gsmmn_pkg;

  localparam int MAX_DIM_DEF   = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int REG_DIM_W     = 7;
  localparam logic [REG_DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_NORM  = 2'd2
  } op_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_NRD,
    ST_NLD,
    ST_NDIV,
    ST_NWR
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic in_wr;
    logic in_rd;
    logic scan_start;
    logic scan;
    logic norm_rd;
    logic div_load;
    logic div_step;
    logic norm_wr;
    logic out_load;
  } gsmmn_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic count_zero;
    logic scan_done;
    logic div_done;
    logic norm_last;
    logic out_free;
  } gsmmn_sts_t;

endpackage

>>> design/gsmmn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gsmmn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/gsmmn_ctrl.sv
// Controller state machine sequencing clear, access and normalize passes.
module gsmmn_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              op_i,
  input  gsmmn_pkg::gsmmn_sts_t   sts_i,
  output gsmmn_pkg::gsmmn_cmd_t   cmd_o
);
  import gsmmn_pkg::*;

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(op_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_READ: state_d = ST_READ;
            OP_NORM: state_d = sts_i.count_zero ? ST_IDLE : ST_SCAN;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: if (sts_i.out_free) state_d = ST_IDLE;
      ST_SCAN: if (sts_i.scan_done) state_d = ST_NRD;
      ST_NRD:  state_d = ST_NLD;
      ST_NLD:  state_d = ST_NDIV;
      ST_NDIV: if (sts_i.div_done) state_d = ST_NWR;
      ST_NWR:  state_d = sts_i.norm_last ? ST_IDLE : ST_NRD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op)
            OP_WRITE: cmd_o.in_wr      = 1'b1;
            OP_READ:  cmd_o.in_rd      = 1'b1;
            OP_NORM:  cmd_o.scan_start = 1'b1;
            default:  ;
          endcase
        end
      end
      ST_READ: cmd_o.out_load = sts_i.out_free;
      ST_SCAN: cmd_o.scan     = 1'b1;
      ST_NRD:  cmd_o.norm_rd  = 1'b1;
      ST_NLD:  cmd_o.div_load = 1'b1;
      ST_NDIV: cmd_o.div_step = 1'b1;
      ST_NWR:  cmd_o.norm_wr  = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> design/gsmmn_dp.sv
// Datapath: cell store, address arithmetic, min-max scan, divider and output register.
module gsmmn_dp #(
  parameter int MAX_DIM   = gsmmn_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = gsmmn_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gsmmn_pkg::gsmmn_cmd_t               cmd_i,
  output gsmmn_pkg::gsmmn_sts_t               sts_o,
  input  logic [gsmmn_pkg::REG_DIM_W-1:0]     width_i,
  input  logic [gsmmn_pkg::REG_DIM_W-1:0]     height_i,
  input  logic [7:0]                          col_i,
  input  logic [7:0]                          row_i,
  input  logic signed [31:0]                  cell_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  read_value_o,
  output logic                                in_range_o
);
  import gsmmn_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CTW   = AW + 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int EW    = (DW > REG_DIM_W) ? DW : REG_DIM_W;
  localparam int CW    = ((DW > 8) ? DW : 8) + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int SW    = $clog2(FRAC_BITS + 1);

  logic [DW-1:0]        w, h;
  logic [CTW-1:0]       count;
  logic                 in_grid;
  logic [AW-1:0]        in_addr, cnt_idx;
  logic [CTW-1:0]       cnt_q, cnt_d;
  logic                 cnt_lt;
  logic                 vld_q, vld_d;
  logic signed [31:0]   min_q, min_d, max_q, max_d;
  logic                 inside_q;
  logic                 out_valid_q;
  logic signed [31:0]   read_value_q;
  logic                 in_range_q;
  logic [33:0]          r_q, r_d;
  logic [QW-1:0]        q_q, q_d;
  logic [SW-1:0]        step_q, step_d;
  logic [32:0]          den, num;
  logic [33:0]          den34;
  logic                 qbit, flat;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [31:0]          ram_wdata, ram_rdata;
  logic signed [31:0]   rdata_s;

  assign w = (EW'(width_i) > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_i);
  assign h = (EW'(height_i) > EW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_i);
  assign count   = CTW'(w * h);
  assign in_grid = (CW'(col_i) < CW'(w)) && (CW'(row_i) < CW'(h));
  assign in_addr = AW'(AW'(col_i) + AW'(row_i) * AW'(w));
  assign cnt_idx = cnt_q[AW-1:0];
  assign cnt_lt  = cnt_q < count;
  assign rdata_s = $signed(ram_rdata);

  assign den   = 33'($signed({max_q[31], max_q}) - $signed({min_q[31], min_q}));
  assign num   = 33'($signed({rdata_s[31], rdata_s}) - $signed({min_q[31], min_q}));
  assign den34 = {1'b0, den};
  assign qbit  = r_q >= den34;
  assign flat  = max_q == min_q;

  assign sts_o.clr_last   = cnt_q == CTW'(DEPTH - 1);
  assign sts_o.count_zero = count == '0;
  assign sts_o.scan_done  = !cnt_lt && !vld_q;
  assign sts_o.div_done   = step_q == SW'(FRAC_BITS);
  assign sts_o.norm_last  = (cnt_q + CTW'(1)) == count;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign ram_we    = cmd_i.clr_wr || cmd_i.norm_wr || (cmd_i.in_wr && in_grid);
  assign ram_waddr = (cmd_i.clr_wr || cmd_i.norm_wr) ? cnt_idx : in_addr;
  assign ram_re    = (cmd_i.in_rd && in_grid) || (cmd_i.scan && cnt_lt) || cmd_i.norm_rd;
  assign ram_raddr = cmd_i.in_rd ? in_addr : cnt_idx;

  always_comb begin
    if (cmd_i.clr_wr) begin
      ram_wdata = '0;
    end else if (cmd_i.norm_wr) begin
      ram_wdata = flat ? 32'd0 : 32'(q_q);
    end else begin
      ram_wdata = cell_value_i;
    end
  end

  gsmmn_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    cnt_d  = cnt_q;
    vld_d  = vld_q;
    min_d  = min_q;
    max_d  = max_q;
    r_d    = r_q;
    q_d    = q_q;
    step_d = step_q;
    if (cmd_i.clr_wr) begin
      cnt_d = sts_o.clr_last ? '0 : cnt_q + CTW'(1);
    end
    if (cmd_i.scan_start) begin
      cnt_d = '0;
      vld_d = 1'b0;
      min_d = 32'sh7FFF_FFFF;
      max_d = 32'sh8000_0000;
    end
    if (cmd_i.scan) begin
      vld_d = cnt_lt;
      if (sts_o.scan_done) begin
        cnt_d = '0;
      end else if (cnt_lt) begin
        cnt_d = cnt_q + CTW'(1);
      end
      if (vld_q) begin
        if (rdata_s > max_q) max_d = rdata_s;
        if (rdata_s < min_q) min_d = rdata_s;
      end
    end
    if (cmd_i.div_load) begin
      r_d    = {1'b0, num};
      q_d    = '0;
      step_d = '0;
    end
    if (cmd_i.div_step) begin
      r_d    = (qbit ? (r_q - den34) : r_q) << 1;
      q_d    = {q_q[QW-2:0], qbit};
      step_d = step_q + SW'(1);
    end
    if (cmd_i.norm_wr) begin
      cnt_d = cnt_q + CTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      vld_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      min_q       <= 32'sh7FFF_FFFF;
      max_q       <= 32'sh8000_0000;
    end else begin
      cnt_q  <= cnt_d;
      vld_q  <= vld_d;
      step_q <= step_d;
      min_q  <= min_d;
      max_q  <= max_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    if (cmd_i.in_rd) begin
      inside_q <= in_grid;
    end
    if (cmd_i.out_load) begin
      read_value_q <= inside_q ? rdata_s : 32'sd0;
      in_range_q   <= inside_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign in_range_o   = in_range_q;

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !flat) |-> r_q < {den, 1'b0})
    else $error("Divider remainder left its bound.");

  a_norm_le_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.norm_wr && !flat) |-> (32'(q_q) <= (32'd1 << FRAC_BITS)))
    else $error("Normalized cell above one.");

  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(read_value_q)))
    else $error("Pending result beat was overwritten.");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> cnt_q <= count)
    else $error("Scan counter ran past the cells in use.");

endmodule

>>> design/grid_store_min_max_normalize.sv
// Top level of the grid store with min-max normalization.
// Cells are signed fixed point with FRAC_BITS fraction bits at flat address col + row*width,
// held in one RAM of MAX_DIM*MAX_DIM words. After reset a clearing pass writes zero to every
// word, during which no input beat is accepted. A read goes through the registered RAM port
// and its result beat waits in an output register. A normalize over N = width*height cells
// runs a min-max scan and then rewrites each cell through a radix-2 divider that produces
// one quotient bit per cycle.
module grid_store_min_max_normalize #(
  parameter int MAX_DIM   = gsmmn_pkg::MAX_DIM_DEF,
  parameter int FRAC_BITS = gsmmn_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         col_i,
  input  logic [7:0]         row_i,
  input  logic signed [31:0] cell_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic               in_range_o
);
  import gsmmn_pkg::*;

  logic [REG_DIM_W-1:0] width_q, height_q;
  logic                 reg_wr;
  reg_idx_e             reg_idx;
  gsmmn_cmd_t           cmd;
  gsmmn_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_GRID_WIDTH:  width_q  <= pwdata[REG_DIM_W-1:0];
        REG_GRID_HEIGHT: height_q <= pwdata[REG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata = 32'(width_q);
      REG_GRID_HEIGHT: prdata = 32'(height_q);
      default:         prdata = '0;
    endcase
  end

  gsmmn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .op_i      (op_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gsmmn_dp #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .width_i     (width_q),
    .height_i    (height_q),
    .col_i       (col_i),
    .row_i       (row_i),
    .cell_value_i(cell_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .in_range_o  (in_range_o)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the grid store with min-max normalization.
`timescale 1ns / 100ps

module testbench;
  import gsmmn_pkg::*;

  localparam int DIM = MAX_DIM_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int DEPTH = DIM * DIM;
  localparam int IDLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] value;
  } grid_cmd_t;

  typedef struct {
    logic [31:0] value;
    logic        in_grid;
  } read_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic [7:0] col_i = '0;
  logic [7:0] row_i = '0;
  logic signed [31:0] cell_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] read_value_o;
  logic in_range_o;

  grid_store_min_max_normalize uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] grid_mem [DEPTH];
  logic [6:0]  width_reg = 7'd64;
  logic [6:0]  height_reg = 7'd64;
  grid_cmd_t   pending_cmds[$];
  read_beat_t  expected_reads[$];
  grid_cmd_t   cur_cmd;
  bit          send_gaps = 1'b1;
  bit          recv_stalls = 1'b1;
  int          send_wait = 0;
  int          recv_wait = 0;
  int          mismatches = 0;
  int          cmds_done = 0;
  int          reads_checked = 0;
  int          normalizes = 0;
  int          idle_cycles = 0;

  function automatic int dim_eff(logic [6:0] r);
    return (r > DIM) ? DIM : int'(r);
  endfunction

  task automatic normalize_grid();
    int cnt;
    longint lo, hi, num, den;
    cnt = dim_eff(width_reg) * dim_eff(height_reg);
    lo = 64'sd2147483647;
    hi = -64'sd2147483648;
    for (int i = 0; i < cnt; i++) begin
      if (longint'($signed(grid_mem[i])) > hi) hi = longint'($signed(grid_mem[i]));
      if (longint'($signed(grid_mem[i])) < lo) lo = longint'($signed(grid_mem[i]));
    end
    for (int i = 0; i < cnt; i++) begin
      if (hi == lo) begin
        grid_mem[i] = '0;
      end else begin
        num = longint'($signed(grid_mem[i])) - lo;
        den = hi - lo;
        grid_mem[i] = 32'((num <<< FRAC) / den);
      end
    end
  endtask

  task automatic apply_cmd(grid_cmd_t c);
    int w, h, addr;
    bit in_grid;
    read_beat_t rb;
    w = dim_eff(width_reg);
    h = dim_eff(height_reg);
    in_grid = (c.col < w) && (c.row < h);
    addr = int'(c.col) + int'(c.row) * w;
    cmds_done++;
    if (c.op == OP_WRITE) begin
      if (in_grid) grid_mem[addr] = c.value;
    end else if (c.op == OP_READ) begin
      rb.value = in_grid ? grid_mem[addr] : '0;
      rb.in_grid = in_grid;
      expected_reads.push_back(rb);
    end else if (c.op == OP_NORM) begin
      normalizes++;
      normalize_grid();
    end
  endtask

  always @(posedge clk_i) begin
    bit fire;
    logic nxt_valid;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      nxt_valid = in_valid_i;
      if (fire) begin
        apply_cmd(cur_cmd);
        send_wait = send_gaps ? $urandom_range(0, 15) : 0;
      end
      if (!in_valid_i || fire) begin
        if (send_wait > 0) begin
          send_wait--;
          nxt_valid = 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          op_i <= cur_cmd.op;
          col_i <= cur_cmd.col;
          row_i <= cur_cmd.row;
          cell_value_i <= cur_cmd.value;
          nxt_valid = 1'b1;
        end else begin
          nxt_valid = 1'b0;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  always @(posedge clk_i) begin
    read_beat_t rb;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        reads_checked++;
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected read beat: value %h in_range %b", read_value_o, in_range_o);
        end else begin
          rb = expected_reads.pop_front();
          if (read_value_o !== rb.value || in_range_o !== rb.in_grid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Read mismatch: expected %h/%b, got %h/%b",
                       rb.value, rb.in_grid, read_value_o, in_range_o);
          end
        end
        recv_wait = recv_stalls ? $urandom_range(0, 15) : 0;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout with %0d reads outstanding.", expected_reads.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [6:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {25'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_GRID_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  task automatic push_cmd(logic [1:0] op, int col, int row, logic [31:0] val);
    grid_cmd_t c;
    c.op = op;
    c.col = 8'(col);
    c.row = 8'(row);
    c.value = val;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    push_cmd(OP_READ, 0, 0, '0);
    while (pending_cmds.size() > 0 || in_valid_i || expected_reads.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(0, 8) << FRAC);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(logic [6:0] w, logic [6:0] h, int n, bit allow_norm);
    int ew, eh, pick;
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    ew = dim_eff(w);
    eh = dim_eff(h);
    send_gaps = ($urandom_range(0, 3) != 0);
    recv_stalls = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (allow_norm && (pick < 4 || i == n / 2)) begin
        push_cmd(OP_NORM, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end else if (pick < 7) begin
        push_cmd(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 255), $urandom);
      end else if (ew == 0 || eh == 0 || pick < 20) begin
        push_cmd((pick % 2) ? OP_WRITE : OP_READ,
                 $urandom_range(0, 255), $urandom_range(0, 255), rand_value());
      end else begin
        push_cmd((i < n / 2 || pick < 45) ? OP_WRITE : OP_READ,
                 $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), rand_value());
      end
    end
    drain();
  endtask

  initial begin
    int w, h;
    for (int i = 0; i < DEPTH; i++) grid_mem[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corner cells at full size, out-of-range accesses, unused op, then a full-grid pass.
    write_reg(REG_GRID_WIDTH, 7'd64);
    write_reg(REG_GRID_HEIGHT, 7'd64);
    push_cmd(OP_WRITE, 0, 0, 32'h8000_0000);
    push_cmd(OP_WRITE, 63, 63, 32'h7fff_ffff);
    push_cmd(OP_WRITE, 5, 9, 32'h0001_0000);
    push_cmd(OP_WRITE, 64, 0, 32'h1234_5678);
    push_cmd(OP_WRITE, 0, 64, 32'h1234_5678);
    push_cmd(OP_WRITE, 255, 255, 32'hffff_ffff);
    push_cmd(OP_UNUSED, 1, 1, 32'h5555_5555);
    push_cmd(OP_READ, 0, 0, '0);
    push_cmd(OP_READ, 63, 63, '0);
    push_cmd(OP_READ, 1, 1, '0);
    push_cmd(OP_READ, 64, 3, '0);
    push_cmd(OP_READ, 3, 255, '0);
    push_cmd(OP_NORM, 0, 0, '0);
    push_cmd(OP_READ, 0, 0, '0);
    push_cmd(OP_READ, 63, 63, '0);
    push_cmd(OP_READ, 5, 9, '0);
    push_cmd(OP_READ, 2, 2, '0);
    drain();

    // A flat grid normalizes to zero; zero sizes leave every cell out of range.
    write_reg(REG_GRID_WIDTH, 7'd1);
    write_reg(REG_GRID_HEIGHT, 7'd1);
    push_cmd(OP_WRITE, 0, 0, 32'h0003_0000);
    push_cmd(OP_NORM, 0, 0, '0);
    push_cmd(OP_READ, 0, 0, '0);
    drain();
    write_reg(REG_GRID_WIDTH, 7'd0);
    push_cmd(OP_WRITE, 0, 0, 32'h0000_0042);
    push_cmd(OP_NORM, 0, 0, '0);
    push_cmd(OP_READ, 0, 0, '0);
    drain();

    random_phase(7'd64, 7'd64, 150, 1'b0);
    random_phase(7'd127, 7'd2, 90, 1'b1);
    random_phase(7'd1, 7'd64, 90, 1'b1);
    random_phase(7'd64, 7'd1, 90, 1'b1);
    random_phase(7'd3, 7'd127, 90, 1'b1);
    random_phase(7'd0, 7'd5, 40, 1'b1);
    random_phase(7'd5, 7'd0, 40, 1'b1);
    random_phase(7'd1, 7'd1, 60, 1'b1);
    while (cmds_done < 1950) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      random_phase(7'(w), 7'(h), $urandom_range(60, 120), 1'b1);
    end
    repeat (20) @(posedge clk_i);

    $display("Ran %0d commands with %0d normalize passes; %0d read beats checked.",
             cmds_done, normalizes, reads_checked);
    $display("Grid sizes covered zero, one, full and saturated dimensions.");
    if (mismatches == 0 && expected_reads.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d reads missing.", mismatches, expected_reads.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> grid_store_min_max_normalize.f
design/gsmmn_pkg.sv
design/gsmmn_ram.sv
design/gsmmn_ctrl.sv
design/gsmmn_dp.sv
design/grid_store_min_max_normalize.sv
tb/testbench.sv
